// ===== hdl/fwdf_pkg.sv =====
// shared types, character codes and tables of the fixed-width decimal formatter
package fwdf_pkg;

  // width of a field length, enough for the largest allowed maximum width
  localparam int LEN_W = 6;
  // entries of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [5:0] CH_SPACE = 6'd32;
  localparam logic [5:0] CH_PLUS  = 6'd43;
  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [5:0] CH_POINT = 6'd46;
  localparam logic [5:0] CH_ZERO  = 6'd48;

  // one classified number, ready for the character emitter
  typedef struct packed {
    logic [14:0]         mag;
    logic [2:0]          exp;
    logic                frac_on;
    logic [LEN_W-1:0]    len;
    logic signed [LEN_W:0] sign_pos;
    logic signed [LEN_W:0] point_pos;
    logic [5:0]          sign_char;
    logic [5:0]          pad_char;
  } job_t;

  // power of ten for a digit exponent
  function automatic logic [13:0] pow10(input logic [2:0] e);
    logic [13:0] p;
    unique case (e)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/fwdf_in_if.sv =====
// input channel: number and layout request
interface fwdf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic [4:0]         field_width;
  logic [2:0]         frac_digits;
  logic               zero_pad;
  logic               show_plus;

  modport source (output valid, value, field_width, frac_digits, zero_pad, show_plus,
                  input ready);
  modport sink (input valid, value, field_width, frac_digits, zero_pad, show_plus,
                output ready);
endinterface

// ===== hdl/fwdf_out_if.sv =====
// output channel: one character of the formatted field
interface fwdf_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] char_code;
  logic [3:0] position;
  logic       last;

  modport source (output valid, char_code, position, last, input ready);
  modport sink (input valid, char_code, position, last, output ready);
endinterface

// ===== hdl/fwdf_front.sv =====
// front part: takes a number and works out its field layout
module fwdf_front
  import fwdf_pkg::*;
#(
  parameter int MAX_WIDTH = 16
) (
  fwdf_in_if.sink    in_item,
  output job_t       job,
  output logic       job_valid,
  input  logic       job_ready
);

  logic        neg;
  logic [15:0] abs16;
  logic [14:0] mag;
  logic        frac_on;
  logic [2:0]  ndig;
  logic [2:0]  k;
  logic [LEN_W-1:0] width;
  logic [LEN_W-1:0] len;

  assign job_valid     = in_item.valid;
  assign in_item.ready = job_ready;

  always_comb begin
    neg     = in_item.value[15];
    abs16   = neg ? (16'd0 - in_item.value) : in_item.value;
    // most negative input saturates
    mag     = abs16[15] ? 15'h7fff : abs16[14:0];
    frac_on = in_item.frac_digits != 3'd0;

    priority if (mag > 15'd9999) begin
      ndig = 3'd5;
    end else if (mag > 15'd999) begin
      ndig = 3'd4;
    end else if (mag > 15'd99) begin
      ndig = 3'd3;
    end else if (mag > 15'd9) begin
      ndig = 3'd2;
    end else begin
      ndig = frac_on ? 3'd2 : 3'd1;
    end
    k = ndig + {2'b00, frac_on};

    width = ({1'b0, in_item.field_width} > LEN_W'(MAX_WIDTH)) ?
            LEN_W'(MAX_WIDTH) : LEN_W'(in_item.field_width);
    len   = (width > LEN_W'(k)) ? width : LEN_W'(k);

    job.mag       = mag;
    job.exp       = ndig - 3'd1;
    job.frac_on   = frac_on;
    job.len       = len;
    job.sign_pos  = (LEN_W+1)'(len) - (LEN_W+1)'(k) - (LEN_W+1)'(1);
    job.point_pos = (LEN_W+1)'(len) - (LEN_W+1)'(in_item.frac_digits) - (LEN_W+1)'(1);
    job.pad_char  = in_item.zero_pad ? CH_ZERO : CH_SPACE;
    priority if (neg) begin
      job.sign_char = CH_MINUS;
    end else if (in_item.show_plus) begin
      job.sign_char = CH_PLUS;
    end else begin
      job.sign_char = in_item.zero_pad ? CH_ZERO : CH_SPACE;
    end
  end

endmodule

// ===== hdl/fwdf_queue.sv =====
// short queue of classified numbers between front and back
module fwdf_queue
  import fwdf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t              store [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = count == (QPTR_W+1)'(QDEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= push_data;
    end
  end

endmodule

// ===== hdl/fwdf_back.sv =====
// back part: walks the field and emits one character per cycle while out_char is not stalled
module fwdf_back
  import fwdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  job_t        q_data,
  input  logic        q_empty,
  output logic        q_pop,
  fwdf_out_if.source  out_char
);

  logic             busy;
  job_t             job;
  logic [LEN_W-1:0] idx;
  logic [14:0]      mag;
  logic [2:0]       exp;
  logic             spent;

  logic             out_valid;
  logic [5:0]       out_code;
  logic [3:0]       out_pos;
  logic             out_last;

  logic             advance;
  logic             fire;
  logic             at_end;
  logic signed [LEN_W:0] sidx;
  logic [5:0]       ch;
  logic             take_digit;
  logic [16:0]      pw;
  logic [16:0]      rem;
  logic [3:0]       q;

  assign out_char.valid     = out_valid;
  assign out_char.char_code = out_code;
  assign out_char.position  = out_pos;
  assign out_char.last      = out_last;

  assign advance = !out_valid || out_char.ready;
  assign fire    = busy && advance;
  assign q_pop   = !busy && !q_empty;
  assign at_end  = idx == (job.len - LEN_W'(1));
  assign sidx    = $signed({1'b0, idx});

  // one decimal digit: quotient by the current power of ten, binary long division
  always_comb begin
    pw  = 17'(pow10(exp));
    rem = 17'(mag);
    q   = '0;
    for (int b = 3; b >= 0; b--) begin
      if (rem >= (pw << b)) begin
        rem  = rem - (pw << b);
        q[b] = 1'b1;
      end
    end
  end

  always_comb begin
    take_digit = 1'b0;
    priority if (sidx < $signed(job.sign_pos)) begin
      ch = job.pad_char;
    end else if (sidx == $signed(job.sign_pos)) begin
      ch = job.sign_char;
    end else if (job.frac_on && sidx == $signed(job.point_pos)) begin
      ch = CH_POINT;
    end else if (!spent) begin
      ch         = CH_ZERO + {2'b00, q};
      take_digit = 1'b1;
    end else begin
      ch = CH_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (fire && at_end) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job   <= q_data;
      idx   <= '0;
      mag   <= q_data.mag;
      exp   <= q_data.exp;
      spent <= 1'b0;
    end else if (fire) begin
      idx <= idx + LEN_W'(1);
      if (take_digit) begin
        mag <= rem[14:0];
        if (exp == 3'd0) begin
          spent <= 1'b1;
        end else begin
          exp <= exp - 3'd1;
        end
      end
    end
    if (fire) begin
      out_code <= ch;
      out_pos  <= idx[3:0];
      out_last <= at_end;
    end
  end

endmodule

// ===== hdl/fixed_width_decimal_formatter.sv =====
// top level of the fixed-width decimal formatter
//
// in_item takes one signed 16-bit number with its layout request (field
// width, fractional digits, zero padding, plus sign). out_item gives the
// characters of the right-aligned field, left to right, one transaction per
// character, with last set on the final one and position counting from 0.
// the field is max(field_width, digits plus point), field_width capped at
// MAX_WIDTH, so a number gives between 1 and MAX_WIDTH characters.
// the front classifies a number in the cycle it is taken and writes it to a
// two-entry queue; in_item.ready is low only while that queue is full.
// the back loads a queued number, then emits one character per cycle while
// out_item is not stalled; it takes the next number only after the last
// character of the current one. the first character reaches out_item through
// the queue, the back's job register and its output register.
// each digit comes from a four-step long division by the current power of
// ten in the back, one digit per emitted digit character.
// when out_item is stalled the character waits in the output register and
// the back holds; the front keeps taking numbers until the queue fills.
// reset (rst, synchronous) empties the queue and drops any character in
// flight; nothing needs clearing before the first transaction.
module fixed_width_decimal_formatter
  import fwdf_pkg::*;
#(
  parameter int MAX_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  fwdf_in_if.sink   in_item,
  fwdf_out_if.source out_item
);

  // classified number from the front
  job_t front_job;
  logic front_valid;
  logic q_full;

  // head of the queue for the back
  job_t q_head;
  logic q_empty;
  logic q_pop;

  fwdf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .in_item   (in_item),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (!q_full)
  );

  // decouples classification from character emission
  fwdf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  // character emitter with its registered output
  fwdf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_char (out_item)
  );

endmodule
